FILE: hdl/tspg_pkg.sv
// ---------------------------------------------------------------------------
// tspg_pkg
// shared types and constants of the trapezoid step profile generator
// ---------------------------------------------------------------------------
package tspg_pkg;

    localparam int COUNT_BITS   = 24;
    localparam int PERIOD_SCALE = 1000000;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HAS_LIMITS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_RATE = 1'd1;

    // operand widths of the shared unit
    localparam int SQ_BITS  = 50;   // up to 2*rate*dist, also v*v
    localparam int RES_BITS = 25;
    localparam int SPEED_MAX  = 33554431;
    localparam int PERIOD_MAX = 1048575;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_LIMIT  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM_MUL,
        ST_LIM_DIV,
        ST_LIM_CHK,
        ST_PREP,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

    typedef struct packed {
        logic             func;
        logic [23:0]      accel_steps;
        logic [23:0]      cruise_steps;
        logic [23:0]      decel_steps;
        logic [19:0]      cruise_speed;
        logic [23:0]      accel_rate;
        logic [23:0]      decel_rate;
        logic             direction;
        logic             limit_end;
        logic             limit_home;
    } t_in_word;

    typedef struct packed {
        logic [19:0]        step_period_us;
        logic signed [31:0] position;
        logic [24:0]        speed_sps;
        logic [1:0]         phase;
        logic               last;
    } t_out_word;

endpackage

FILE: hdl/tspg_if.sv
// ---------------------------------------------------------------------------
// tspg_if
// valid/ready channel carrying one word
// ---------------------------------------------------------------------------
interface tspg_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/trapezoid_step_profile_generator.sv
// a start word is loaded when taken; a step word passes the limit check, then one divide in
// cruise, or multiply, square root and divide in a ramp, each a pass of the shared alu
// a limit check that triggers adds a multiply and a divide; a stop with no steps emits nothing
// throughput: one word at a time, set by the single shared alu; a waiting result blocks input
// reset: synchronous active low, move idle, direction 1, position and counters 0
// ---------------------------------------------------------------------------
// trapezoid_step_profile_generator
// trapezoidal stepper profile: per step speed, period and position
// ---------------------------------------------------------------------------
module trapezoid_step_profile_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tspg_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tspg_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    tspg_if.sink                                i_in,
    tspg_if.source                              o_out
);
    import tspg_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic        r_has_limits;
    logic [23:0] r_limit_rate;

    // move state
    t_state               r_state, n_state;
    logic                 r_active, n_active;
    t_phase               r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_idx, n_idx;
    logic [COUNT_BITS-1:0] r_cnt [3];
    logic [COUNT_BITS-1:0] r_stop_total, n_stop_total;
    logic [23:0]          r_arate, r_drate;
    logic [19:0]          r_cruise;
    logic                 r_dir;
    logic [31:0]          r_pos, n_pos;
    logic [24:0]          r_last_speed, n_last_speed;
    logic [24:0]          r_speed, n_speed;
    logic                 r_lim_l, r_lim_h;

    // output register
    logic      r_ov, n_ov;
    t_out_word r_ow, n_ow;

    // alu
    t_alu_cmd           w_cmd;
    t_alu_stat          w_stat;
    logic [SQ_BITS-1:0] w_a, w_b, w_res;

    tspg_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_stat (w_stat),
        .o_res  (w_res)
    );

    // helpers
    logic [COUNT_BITS-1:0] w_total, w_dist, w_idx1;
    logic [24:0]           w_cruise1, w_v;
    logic [23:0]           w_rate;
    logic                  w_hit;
    logic                  w_in_fire;
    t_phase                w_next_phase;
    logic                  w_next_none;
    logic [24:0]           w_speed_sat;
    logic [SQ_BITS-1:0]    w_period;

    assign w_in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && !(r_ov && !o_out.ready);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_ow;

    always_comb begin
        w_cruise1 = (r_cruise == '0) ? 25'd1 : {5'd0, r_cruise};
        w_v = (r_phase == PH_CRUISE) ? w_cruise1
            : ((r_last_speed == '0) ? 25'd1 : r_last_speed);
        w_total = (r_phase == PH_LIMIT) ? r_stop_total : r_cnt[r_phase];
        w_dist  = (r_idx < w_total) ? w_total - r_idx : '0;
        w_idx1  = r_idx + 1'b1;
        unique case (r_phase)
            PH_ACCEL: w_rate = r_arate;
            PH_DECEL: w_rate = r_drate;
            default:  w_rate = r_limit_rate;
        endcase
        w_hit = r_has_limits && (r_phase != PH_LIMIT) &&
                (r_dir ? r_lim_l : r_lim_h);
        // next non-empty phase after this one
        w_next_none  = 1'b1;
        w_next_phase = PH_ACCEL;
        if (r_phase == PH_ACCEL && r_cnt[1] != '0) begin
            w_next_none = 1'b0; w_next_phase = PH_CRUISE;
        end else if ((r_phase == PH_ACCEL || r_phase == PH_CRUISE) && r_cnt[2] != '0) begin
            w_next_none = 1'b0; w_next_phase = PH_DECEL;
        end
        w_speed_sat = (w_res[SQ_BITS-1:25] != '0) ? 25'(SPEED_MAX) : w_res[24:0];
        if (w_speed_sat == '0) w_speed_sat = 25'd1;
        w_period = w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_limits <= 1'b0;
            r_limit_rate <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HAS_LIMITS: r_has_limits <= i_cfg_data[0];
                default:        r_limit_rate <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= 1'b0;
            r_phase      <= PH_ACCEL;
            r_idx        <= '0;
            r_cnt        <= '{default: '0};
            r_stop_total <= '0;
            r_arate      <= '0;
            r_drate      <= '0;
            r_cruise     <= '0;
            r_dir        <= 1'b1;
            r_pos        <= '0;
            r_last_speed <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_stop_total <= n_stop_total;
            r_pos        <= n_pos;
            r_last_speed <= n_last_speed;
            r_ov         <= n_ov;
            // a start word loads the move
            if (w_in_fire && !i_in.data.func) begin
                r_cnt[0] <= i_in.data.accel_steps;
                r_cnt[1] <= i_in.data.cruise_steps;
                r_cnt[2] <= i_in.data.decel_steps;
                r_arate  <= i_in.data.accel_rate;
                r_drate  <= i_in.data.decel_rate;
                r_cruise <= i_in.data.cruise_speed;
                r_dir    <= i_in.data.direction;
            end
        end
        r_speed <= n_speed;
        r_ow    <= n_ow;
        if (w_in_fire) begin
            r_lim_l <= i_in.data.limit_end;
            r_lim_h <= i_in.data.limit_home;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_stop_total = r_stop_total;
        n_pos        = r_pos;
        n_last_speed = r_last_speed;
        n_speed      = r_speed;
        n_ov         = r_ov && !o_out.ready;
        n_ow         = r_ow;
        w_cmd.start  = 1'b0;
        w_cmd.op     = OP_MUL;
        w_a          = '0;
        w_b          = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (!i_in.data.func) begin
                        n_idx        = '0;
                        n_last_speed = '0;
                        n_stop_total = '0;
                        n_active     = 1'b1;
                        if (i_in.data.accel_steps != '0)       n_phase = PH_ACCEL;
                        else if (i_in.data.cruise_steps != '0) n_phase = PH_CRUISE;
                        else if (i_in.data.decel_steps != '0)  n_phase = PH_DECEL;
                        else                                   n_active = 1'b0;
                    end else if (r_active) begin
                        n_state = ST_LIM_MUL;
                    end
                end
            end
            ST_LIM_MUL: begin
                // limit check uses the latched switch flags
                if (w_hit) begin
                    if (r_limit_rate == '0) begin
                        n_active = 1'b0; n_idx = '0; n_last_speed = '0;
                        n_state  = ST_IDLE;
                    end else begin
                        w_cmd.start = 1'b1; w_cmd.op = OP_MUL;
                        w_a = SQ_BITS'(w_v); w_b = SQ_BITS'(w_v);
                        n_state = ST_LIM_DIV;
                    end
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_LIM_DIV: begin
                if (w_stat.done) begin
                    w_cmd.start = 1'b1; w_cmd.op = OP_DIV;
                    w_a = w_res; w_b = SQ_BITS'({r_limit_rate, 1'b0});
                    n_state = ST_LIM_CHK;
                end
            end
            ST_LIM_CHK: begin
                if (w_stat.done) begin
                    if (w_res == '0) begin
                        n_active = 1'b0; n_idx = '0; n_last_speed = '0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_stop_total = (w_res > SQ_BITS'(COUNT_MAX)) ? COUNT_MAX
                                       : w_res[COUNT_BITS-1:0];
                        n_idx   = '0;
                        n_phase = PH_LIMIT;
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                if (r_phase == PH_CRUISE) begin
                    n_speed = w_cruise1;
                    w_cmd.start = 1'b1; w_cmd.op = OP_DIV;
                    w_a = SQ_BITS'(PERIOD_SCALE); w_b = SQ_BITS'(w_cruise1);
                    n_state = ST_OUT;
                end else begin
                    w_cmd.start = 1'b1; w_cmd.op = OP_MUL;
                    w_a = SQ_BITS'({w_rate, 1'b0});
                    w_b = SQ_BITS'((r_phase == PH_ACCEL) ? r_idx : w_dist);
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_stat.done) begin
                    w_cmd.start = 1'b1; w_cmd.op = OP_SQRT;
                    w_a = w_res;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (w_stat.done) begin
                    n_speed = w_speed_sat;
                    w_cmd.start = 1'b1; w_cmd.op = OP_DIV;
                    w_a = SQ_BITS'(PERIOD_SCALE); w_b = SQ_BITS'(w_speed_sat);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_stat.done && !(r_ov && !o_out.ready)) begin
                    n_pos = r_dir ? r_pos + 32'd1 : r_pos - 32'd1;
                    n_ow.position  = signed'(n_pos);
                    n_ow.speed_sps = r_speed;
                    n_ow.phase     = r_phase;
                    n_ow.step_period_us = (w_period == '0) ? 20'd1
                        : (w_period > SQ_BITS'(PERIOD_MAX)) ? 20'(PERIOD_MAX)
                        : w_period[19:0];
                    n_ow.last = 1'b0;
                    n_idx = w_idx1;
                    if (w_idx1 >= w_total) begin
                        n_idx = '0;
                        if (r_phase == PH_LIMIT || w_next_none) begin
                            n_active  = 1'b0;
                            n_ow.last = 1'b1;
                        end else begin
                            n_phase = w_next_phase;
                        end
                    end
                    n_last_speed = n_ow.last ? 25'd0 : r_speed;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // no word is taken while the shared unit is working
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !i_in.ready)
        else $error("input taken while alu busy");
    // a held result is never overwritten
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)))
        else $error("pending result lost");
    // the last step always closes the move
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) && r_ow.last |-> !r_active)
        else $error("last step but move still active");
`endif
endmodule

FILE: hdl/tspg_alu.sv
// ---------------------------------------------------------------------------
// tspg_alu
// shared multi-cycle unit: shift-add multiply, bitwise square root, divide
// ---------------------------------------------------------------------------
module tspg_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tspg_pkg::t_alu_cmd         i_cmd,
    input  logic [tspg_pkg::SQ_BITS-1:0] i_a,
    input  logic [tspg_pkg::SQ_BITS-1:0] i_b,
    output tspg_pkg::t_alu_stat        o_stat,
    output logic [tspg_pkg::SQ_BITS-1:0] o_res
);
    import tspg_pkg::*;

    localparam int CNT_BITS = $clog2(SQ_BITS + 1);

    t_op                 r_op, n_op;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [SQ_BITS-1:0]  r_acc, n_acc;   // product, remainder
    logic [SQ_BITS-1:0]  r_x, n_x;       // multiplicand, radicand, dividend
    logic [SQ_BITS-1:0]  r_y, n_y;       // multiplier, divisor
    logic [SQ_BITS-1:0]  r_q, n_q;       // root or quotient

    logic [SQ_BITS+1:0]  w_trial;
    logic [SQ_BITS+1:0]  w_rem2;
    logic [SQ_BITS:0]    w_drem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_q   <= n_q;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_q    = r_q;
        // square root: two radicand bits in per step
        w_rem2  = {r_acc, r_x[SQ_BITS-1 -: 2]};
        w_trial = {r_q, 2'b01};
        // restoring divide: one dividend bit in per step
        w_drem  = {r_acc, r_x[SQ_BITS-1]};
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_op   = i_cmd.op;
            n_acc  = '0;
            n_q    = '0;
            n_x    = i_a;
            n_y    = i_b;
            n_cnt  = (i_cmd.op == OP_SQRT) ? CNT_BITS'(SQ_BITS / 2)
                                           : CNT_BITS'(SQ_BITS);
        end else if (r_busy) begin
            unique case (r_op)
                OP_MUL: begin
                    if (r_y[0]) n_acc = r_acc + r_x;
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
                OP_SQRT: begin
                    n_x = r_x << 2;
                    if (w_rem2 >= w_trial) begin
                        n_acc = SQ_BITS'(w_rem2 - w_trial);
                        n_q   = {r_q[SQ_BITS-2:0], 1'b1};
                    end else begin
                        n_acc = SQ_BITS'(w_rem2);
                        n_q   = {r_q[SQ_BITS-2:0], 1'b0};
                    end
                end
                default: begin
                    n_x = r_x << 1;
                    if (w_drem >= {1'b0, r_y}) begin
                        n_acc = SQ_BITS'(w_drem - {1'b0, r_y});
                        n_q   = {r_q[SQ_BITS-2:0], 1'b1};
                    end else begin
                        n_acc = SQ_BITS'(w_drem);
                        n_q   = {r_q[SQ_BITS-2:0], 1'b0};
                    end
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = (r_op == OP_MUL) ? r_acc : r_q;
endmodule

FILE: tb/sv/trapezoid_step_profile_generator_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trapezoid_step_profile_generator_test
// drives move and step words into the profile generator, predicts every
// step (speed, period, position, phase, last flag) and checks the results
// ---------------------------------------------------------------------------
module trapezoid_step_profile_generator_test;
    import tspg_pkg::*;

    localparam int  RUN_ITEMS   = 1550;
    localparam int  SETTLE      = 400;       // covers the worst step, limit stop included
    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint unsigned COUNT_MAX = 64'hFFFFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = CFG_HAS_LIMITS;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    tspg_if #(.T(t_in_word))  in_ch ();
    tspg_if #(.T(t_out_word)) out_ch ();

    trapezoid_step_profile_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // run bookkeeping
    longint    cycles = 0;
    int        words_sent = 0;
    int        steps_seen = 0;
    int        limit_steps = 0;
    int        mismatches = 0;
    bit        gaps_on = 1'b1;     // sender idling
    bit        stalls_on = 1'b1;   // receiver back-pressure
    t_out_word expected_steps[$];

    // ---------------------------------------------------------------------
    // profile predictor: own copy of registers and move state
    // ---------------------------------------------------------------------
    bit                limits_on;
    logic [23:0]       stop_rate;
    bit                moving;
    t_phase            cur_ph;
    longint unsigned   step_no;
    longint unsigned   ph_len[3];
    longint unsigned   acc_rate, dec_rate, cruise_spd;
    bit                fwd;
    logic [31:0]       axis_pos;
    longint unsigned   prev_speed;
    longint unsigned   stop_len;

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 26; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // first non-empty phase at or after p, else the move is over
    function automatic void enter_from(int p);
        moving = 1'b0;
        for (int k = p; k < 3; k++) begin
            if (ph_len[k] != 0) begin
                moving = 1'b1;
                cur_ph = t_phase'(k);
                break;
            end
        end
    endfunction

    function automatic void predictor_reset();
        limits_on  = 1'b0;
        stop_rate  = '0;
        moving     = 1'b0;
        cur_ph     = PH_ACCEL;
        step_no    = 0;
        ph_len     = '{0, 0, 0};
        acc_rate   = 0;
        dec_rate   = 0;
        cruise_spd = 0;
        fwd        = 1'b1;
        axis_pos   = '0;
        prev_speed = 0;
        stop_len   = 0;
    endfunction

    function automatic void predict_step(t_in_word w);
        longint unsigned cr, v, n, total, remain, spd, per;
        t_phase          ph;
        bit              fin;
        t_out_word       r;
        if (!w.func) begin
            // new move: drops whatever was running, keeps the position
            ph_len[0]  = w.accel_steps;
            ph_len[1]  = w.cruise_steps;
            ph_len[2]  = w.decel_steps;
            acc_rate   = w.accel_rate;
            dec_rate   = w.decel_rate;
            cruise_spd = w.cruise_speed;
            fwd        = w.direction;
            step_no    = 0;
            prev_speed = 0;
            stop_len   = 0;
            enter_from(0);
            return;
        end
        if (!moving) return;
        cr = (cruise_spd != 0) ? cruise_spd : 1;
        if (cur_ph != PH_LIMIT && limits_on && (fwd ? w.limit_end : w.limit_home)) begin
            v = (cur_ph == PH_CRUISE) ? cr : ((prev_speed != 0) ? prev_speed : 1);
            n = 0;
            if (stop_rate != 0) n = (v * v) / (2 * longint'(stop_rate));
            if (n == 0) begin
                // stop at once, nothing emitted
                moving     = 1'b0;
                step_no    = 0;
                prev_speed = 0;
                return;
            end
            if (n > COUNT_MAX) n = COUNT_MAX;
            stop_len = n;
            step_no  = 0;
            cur_ph   = PH_LIMIT;
        end
        ph     = cur_ph;
        total  = (ph == PH_LIMIT) ? stop_len : ph_len[ph];
        remain = (step_no < total) ? total - step_no : 0;
        case (ph)
            PH_ACCEL:  spd = int_root(2 * acc_rate * step_no);
            PH_CRUISE: spd = cr;
            PH_DECEL:  spd = int_root(2 * dec_rate * remain);
            default:   spd = int_root(2 * longint'(stop_rate) * remain);
        endcase
        if (spd < 1) spd = 1;
        if (spd > SPEED_MAX) spd = SPEED_MAX;
        per = PERIOD_SCALE / spd;
        if (per < 1) per = 1;
        if (per > PERIOD_MAX) per = PERIOD_MAX;
        axis_pos = fwd ? axis_pos + 1 : axis_pos - 1;
        step_no++;
        fin = 1'b0;
        if (step_no >= total) begin
            step_no = 0;
            if (ph == PH_LIMIT) moving = 1'b0;
            else enter_from(int'(ph) + 1);
            fin = !moving;
        end
        prev_speed = fin ? 0 : spd;
        r.step_period_us = per[19:0];
        r.position       = axis_pos;
        r.speed_sps      = spd[24:0];
        r.phase          = ph;
        r.last           = fin;
        expected_steps.push_back(r);
    endfunction

    // ---------------------------------------------------------------------
    // sender, receiver, checker, watchdog
    // ---------------------------------------------------------------------

    // valid stays high between back-to-back words; it is lowered on a gap and when draining
    task automatic send_word(t_in_word w);
        if (gaps_on && $urandom_range(99) < 18) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_step(w);
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= stalls_on ? ($urandom_range(99) >= 18) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d steps outstanding",
                     cycles, expected_steps.size());
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            steps_seen++;
            if (out_ch.data.phase == PH_LIMIT) limit_steps++;
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected step word %p", out_ch.data);
            end else begin
                want = expected_steps.pop_front();
                if (out_ch.data.step_period_us !== want.step_period_us ||
                    out_ch.data.position !== want.position ||
                    out_ch.data.speed_sps !== want.speed_sps ||
                    out_ch.data.phase !== want.phase ||
                    out_ch.data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("step %0d mismatch: want per %0d pos %0d spd %0d ph %0d last %0d, got per %0d pos %0d spd %0d ph %0d last %0d",
                                 steps_seen, want.step_period_us, want.position,
                                 want.speed_sps, want.phase, want.last,
                                 out_ch.data.step_period_us, out_ch.data.position,
                                 out_ch.data.speed_sps, out_ch.data.phase,
                                 out_ch.data.last);
                end
            end
        end
    end

    // wait for every step to come back, then let a silent stop settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // registers only change once the block has gone quiet
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HAS_LIMITS) limits_on = val[0];
        else stop_rate = val;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // word builders
    // ---------------------------------------------------------------------
    function automatic t_in_word junk_word();
        logic [191:0] b;
        b = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return b[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word move_word(int a, int c, int d, int spd,
                                           int ar, int dr, bit dir);
        t_in_word w;
        w = '0;
        w.func = 1'b0;
        w.accel_steps = 24'(a);  w.cruise_steps = 24'(c);  w.decel_steps = 24'(d);
        w.cruise_speed = 20'(spd);
        w.accel_rate = 24'(ar);  w.decel_rate = 24'(dr);
        w.direction = dir;
        // switch flags are ignored on a move word
        w.limit_end = 1'($urandom_range(1));
        w.limit_home = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic t_in_word step_word(bit lim_end, bit lim_home);
        t_in_word w;
        w = junk_word();   // junk in the unused fields
        w.func = 1'b1;
        w.limit_end = lim_end;
        w.limit_home = lim_home;
        return w;
    endfunction

    function automatic t_in_word random_move();
        t_in_word w;
        if ($urandom_range(99) < 8) begin
            // fully random fields, mostly long moves that get dropped
            w = junk_word();
            w.func = 1'b0;
            return w;
        end
        w = move_word($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 6),
                      $urandom_range(3) == 0 ? $urandom_range(0, 20) :
                                               $urandom_range(0, 20'hFFFFF),
                      $urandom_range(1) ? $urandom_range(0, 5000) :
                                          $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(1) ? $urandom_range(0, 5000) :
                                          $urandom_range(0, 24'hFFFFFF),
                      1'($urandom_range(1)));
        return w;
    endfunction

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------
    task automatic test_directed_moves();
        send_word(step_word(1'b1, 1'b1));                            // step while idle
        send_word(move_word(0, 0, 0, 100, 100, 100, 1'b1));          // empty move
        send_word(step_word(1'b0, 1'b0));
        send_word(move_word(3, 2, 3, 0, 0, 0, 1'b1));                // zero speed and rates
        repeat (8) send_word(step_word(1'b1, 1'b1));
        send_word(move_word(2, 0, 2, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));  // top speeds
        repeat (4) send_word(step_word(1'b0, 1'b0));
        send_word(move_word(0, 3, 0, 20'hFFFFF, 0, 0, 1'b0));        // cruise only
        repeat (2) send_word(step_word(1'b0, 1'b1));
        // new move while one is running, huge counts
        send_word(move_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 24'hFFFFFF, 1, 1'b1));
        repeat (3) send_word(step_word(1'b0, 1'b0));
        drain();
    endtask

    task automatic test_limit_stops();
        write_reg(CFG_HAS_LIMITS, 24'd1);
        write_reg(CFG_LIMIT_RATE, 24'd0);                            // stop at once
        send_word(move_word(4, 2, 4, 1000, 5000, 5000, 1'b1));
        send_word(step_word(1'b0, 1'b1));                            // wrong switch
        send_word(step_word(1'b1, 1'b0));
        send_word(step_word(1'b0, 1'b0));                            // idle again
        write_reg(CFG_LIMIT_RATE, 24'd1000);
        send_word(move_word(0, 4, 2, 500, 0, 3000, 1'b0));
        send_word(step_word(1'b0, 1'b1));                            // stop from cruise
        repeat (3) send_word(step_word(1'b1, 1'b1));                 // no recheck while stopping
        write_reg(CFG_LIMIT_RATE, 24'hFFFFFF);
        send_word(move_word(5, 0, 0, 10, 24'hFFFFFF, 0, 1'b1));
        repeat (2) send_word(step_word(1'b0, 1'b0));
        send_word(step_word(1'b1, 1'b0));                            // stop length rounds to zero
        write_reg(CFG_LIMIT_RATE, 24'd1);
        send_word(move_word(0, 2, 0, 20'hFFFFF, 0, 0, 1'b1));
        repeat (3) send_word(step_word(1'b1, 1'b0));                 // saturated stop length
        drain();
    endtask

    task automatic random_setting(int round);
        case (round % 5)
            0: begin write_reg(CFG_HAS_LIMITS, 24'd0); write_reg(CFG_LIMIT_RATE, 24'hFFFFFF); end
            1: begin write_reg(CFG_HAS_LIMITS, 24'd1); write_reg(CFG_LIMIT_RATE, 24'd0); end
            2: begin write_reg(CFG_HAS_LIMITS, 24'd1); write_reg(CFG_LIMIT_RATE, 24'hFFFFFF); end
            3: begin write_reg(CFG_HAS_LIMITS, 24'd1);
                     write_reg(CFG_LIMIT_RATE, 24'($urandom_range(50, 20000))); end
            default: begin write_reg(CFG_HAS_LIMITS, 24'($urandom_range(1)));
                     write_reg(CFG_LIMIT_RATE, 24'($urandom_range(0, 24'hFFFFFF))); end
        endcase
    endtask

    task automatic test_random_moves();
        int round;
        int reqs;
        int chunk_end;
        t_in_word mv;
        round = 0;
        while (words_sent < RUN_ITEMS) begin
            random_setting(round);
            // one chunk runs with no idling on either side
            gaps_on   = (round != 2);
            stalls_on = (round != 2);
            chunk_end = words_sent + 200;
            while (words_sent < chunk_end && words_sent < RUN_ITEMS) begin
                mv = random_move();
                send_word(mv);
                reqs = mv.accel_steps + mv.cruise_steps + mv.decel_steps;
                if (reqs > 24) reqs = $urandom_range(1, 12);
                else if ($urandom_range(4) == 0) reqs = $urandom_range(0, reqs);
                else reqs += $urandom_range(0, 3);
                repeat (reqs)
                    send_word(step_word($urandom_range(99) < 6, $urandom_range(99) < 6));
                if ($urandom_range(9) == 0) begin
                    // noise: random words of either kind
                    repeat ($urandom_range(1, 3))
                        send_word(junk_word());
                end
            end
            drain();
            round++;
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        predictor_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_moves();
        test_limit_stops();
        test_random_moves();
        drain();
        $display("sent %0d words, checked %0d steps (%0d in limit stops), %0d mismatches",
                 words_sent, steps_seen, limit_steps, mismatches);
        if (mismatches == 0 && expected_steps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
